// ===== design/atm_pkg.sv =====
package atm_pkg;

	localparam int INPUT_FRAC_BITS_DEF = 16;
	localparam logic [15:0] EXPOSURE_RESET = 16'd4096;

	typedef struct packed {
		logic [23:0] red_linear;
		logic [23:0] green_linear;
		logic [23:0] blue_linear;
	} pixel_in_t;

	typedef struct packed {
		logic [7:0] red_display;
		logic [7:0] green_display;
		logic [7:0] blue_display;
	} pixel_out_t;

	localparam logic [15:0] MAT_IN [9] = '{
		16'd39137, 16'd23238, 16'd3161,
		16'd4981, 16'd59529, 16'd1026,
		16'd1861, 16'd8771, 16'd54904};

	localparam logic signed [17:0] MAT_OUT [9] = '{
		18'sd105169, -18'sd34805, -18'sd4828,
		-18'sd6690, 18'sd72622, -18'sd396,
		-18'sd214, -18'sd4768, 18'sd70518};

	localparam logic [63:0] CURVE_A40 = 64'd27024456494;
	localparam logic [63:0] CURVE_B48 = 64'd25483899966;
	localparam logic [63:0] CURVE_C24 = 64'd16504234;
	localparam logic [63:0] CURVE_D40 = 64'd476034658757;
	localparam logic [63:0] CURVE_E48 = 64'd67013843930250;

	localparam int DEN_W = 63;
	localparam int REM_W = DEN_W + 3;
	localparam int QUO_W = 26;
	localparam int DIV_STEPS = 2;
	localparam int DIV_STAGES = QUO_W / DIV_STEPS;
	localparam int CURVE_W = QUO_W + 1;

	typedef logic signed [CURVE_W-1:0] curve_t;

	localparam logic [24:0] ONE_Q24 = 25'h1000000;

	localparam int THR_W = 25;
	localparam int SRGB_SEARCH_STAGES = 4;
	localparam logic [24:0] SRGB_LIN_LIMIT = 25'd52526;
	localparam logic [40:0] SRGB_LIN_MUL = 41'd32946;
	localparam logic [40:0] SRGB_LIN_BIAS = 41'd83886080;
	localparam logic [40:0] SRGB_LIN_STEP = 41'd167772160;
	localparam int SRGB_LIN_CODES = 10;

	function automatic logic [299:0] big_pow(input logic [299:0] b, input int n);
		logic [299:0] r;
		r = 300'd1;
		for (int i = 0; i < n; i++) begin
			r = r * b;
		end
		return r;
	endfunction

	// smallest Q.24 level that reaches each display code of the power segment
	function automatic logic [256*THR_W-1:0] srgb_thresholds();
		logic [256*THR_W-1:0] tab;
		logic [299:0] pfac;
		logic [299:0] rhs;
		logic [299:0] lhs;
		logic [25:0] lo;
		logic [25:0] hi;
		logic [25:0] mid;
		tab = '0;
		pfac = big_pow(300'd10761, 12);
		for (int k = 1; k < 256; k++) begin
			rhs = big_pow(300'(40 * k + 541), 12) << 120;
			lo = 26'd1;
			hi = 26'h1000001;
			while (lo < hi) begin
				mid = (lo + hi) >> 1;
				lhs = big_pow(300'(mid), 5) * pfac;
				if (lhs >= rhs) begin
					hi = mid;
				end else begin
					lo = mid + 26'd1;
				end
			end
			tab[k*THR_W +: THR_W] = lo[THR_W-1:0];
		end
		return tab;
	endfunction

endpackage

// ===== design/aces_tonemap_srgb_encode.sv =====
// done follows start through in_stage, curve, div, out_mix, srgb and the done register.
// Throughput: one pixel per cycle; busy stays low, a pixel may follow on every edge.
// Depth is set by the 13-stage divider of the tonemap curve, two quotient bits a stage.
// The receiver cannot stall: each result is on display for the single cycle of done.
// Reset (arst_n low) clears all valid bits and loads gain_q with 1.0.
module aces_tonemap_srgb_encode #(
	parameter int INPUT_FRAC_BITS = atm_pkg::INPUT_FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                cfg_wr_en,
	input  logic [15:0]         cfg_wr_data,
	input  atm_pkg::pixel_in_t  pixel,
	output logic                done,
	output atm_pkg::pixel_out_t display
);

	localparam int V_W = 49 - INPUT_FRAC_BITS;
	localparam int LATENCY = 3 + 4 + atm_pkg::DIV_STAGES + 2
		+ atm_pkg::SRGB_SEARCH_STAGES + 2;

	logic [15:0] gain_q;
	logic mix_vld;
	logic [2:0][V_W-1:0] mix_v;
	logic cur_vld [3];
	logic [atm_pkg::DEN_W-1:0] cur_mag [3];
	logic [atm_pkg::DEN_W-1:0] cur_den [3];
	logic cur_neg [3];
	logic div_vld [3];
	atm_pkg::curve_t div_q [3];
	logic out_vld;
	logic [24:0] out_c [3];
	logic enc_vld [3];
	logic [7:0] enc_code [3];
	logic done_q;
	atm_pkg::pixel_out_t display_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= atm_pkg::EXPOSURE_RESET;
		end else if (cfg_wr_en) begin
			gain_q <= cfg_wr_data;
		end
	end

	atm_in_stage #(
		.INPUT_FRAC_BITS(INPUT_FRAC_BITS)
	) u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.pixel    (pixel),
		.gain     (gain_q),
		.out_valid(mix_vld),
		.v        (mix_v)
	);

	for (genvar i = 0; i < 3; i++) begin : g_lane
		atm_curve #(
			.INPUT_FRAC_BITS(INPUT_FRAC_BITS)
		) u_curve (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (mix_vld),
			.v        (mix_v[i]),
			.out_valid(cur_vld[i]),
			.mag      (cur_mag[i]),
			.den      (cur_den[i]),
			.neg      (cur_neg[i])
		);

		atm_div u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (cur_vld[i]),
			.mag      (cur_mag[i]),
			.den      (cur_den[i]),
			.neg      (cur_neg[i]),
			.out_valid(div_vld[i]),
			.quo      (div_q[i])
		);

		atm_srgb u_srgb (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (out_vld),
			.c        (out_c[i]),
			.out_valid(enc_vld[i]),
			.code     (enc_code[i])
		);
	end

	atm_out_mix u_out_mix (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (div_vld[0]),
		.r        (div_q),
		.out_valid(out_vld),
		.c        (out_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= enc_vld[0];
		end
	end

	always_ff @(posedge clk) begin
		display_q.red_display <= enc_code[0];
		display_q.green_display <= enc_code[1];
		display_q.blue_display <= enc_code[2];
	end

	assign done = done_q;
	assign display = display_q;

	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_vld[0] == cur_vld[1]) && (cur_vld[1] == cur_vld[2])
		&& (div_vld[0] == div_vld[1]) && (div_vld[1] == div_vld[2])
		&& (enc_vld[0] == enc_vld[1]) && (enc_vld[1] == enc_vld[2]))
		else $error("color lanes out of step");

	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result beat without matching start");

endmodule

// ===== design/atm_in_stage.sv =====
module atm_in_stage #(
	parameter int INPUT_FRAC_BITS = atm_pkg::INPUT_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  atm_pkg::pixel_in_t            pixel,
	input  logic [15:0]                   gain,
	output logic                          out_valid,
	output logic [2:0][48-INPUT_FRAC_BITS:0] v
);

	localparam int LIN_W = 48 - INPUT_FRAC_BITS;
	localparam int V_W = LIN_W + 1;
	localparam int LIN_SHIFT = 24 - INPUT_FRAC_BITS;

	logic [23:0] x [3];
	logic [23:0] e_comb [3];
	logic [23:0] e_s1 [3];
	logic [LIN_W-1:0] lin [3];
	logic [LIN_W+15:0] prod_s2 [3][3];
	logic [LIN_W+17:0] acc [3];
	logic [V_W-1:0] v_s3 [3];
	logic vld_s1;
	logic vld_s2;
	logic vld_s3;

	assign x[0] = pixel.red_linear;
	assign x[1] = pixel.green_linear;
	assign x[2] = pixel.blue_linear;

	always_comb begin
		logic [40:0] rnd;
		rnd = '0;
		for (int c = 0; c < 3; c++) begin
			rnd = 41'(x[c]) * 41'(gain) + 41'd2048;
			e_comb[c] = (rnd[40:36] != '0) ? '1 : rnd[35:12];
			lin[c] = LIN_W'(e_s1[c]) << LIN_SHIFT;
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			acc[r] = (LIN_W+18)'(prod_s2[r][0]) + (LIN_W+18)'(prod_s2[r][1])
				+ (LIN_W+18)'(prod_s2[r][2]) + (LIN_W+18)'(32768);
			v[r] = v_s3[r];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		e_s1 <= e_comb;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				prod_s2[r][c] <= (LIN_W+16)'(atm_pkg::MAT_IN[r*3+c]) * (LIN_W+16)'(lin[c]);
			end
			v_s3[r] <= acc[r][LIN_W+16:16];
		end
	end

	assign out_valid = vld_s3;

endmodule

// ===== design/atm_curve.sv =====
module atm_curve #(
	parameter int INPUT_FRAC_BITS = atm_pkg::INPUT_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [48-INPUT_FRAC_BITS:0]   v,
	output logic                          out_valid,
	output logic [atm_pkg::DEN_W-1:0]     mag,
	output logic [atm_pkg::DEN_W-1:0]     den,
	output logic                          neg
);

	localparam int V_W = 49 - INPUT_FRAC_BITS;

	logic [4:0] k;
	logic [30:0] vs_c;
	logic [30:0] vs_s1;
	logic [18:0] a_s1;
	logic [34:0] b_s1;
	logic [22:0] d_s1;
	logic [45:0] e_s1;
	logic [61:0] sq_s2;
	logic [49:0] ta_s2;
	logic [53:0] td_s2;
	logic [34:0] b_s2;
	logic [45:0] e_s2;
	logic [61:0] ch_s3;
	logic [23:0] cl_s3;
	logic [63:0] num_s3;
	logic [53:0] td_s3;
	logic [45:0] e_s3;
	logic [atm_pkg::DEN_W-1:0] den_s4;
	logic [atm_pkg::DEN_W-1:0] mag_s4;
	logic neg_s4;
	logic vld_s1;
	logic vld_s2;
	logic vld_s3;
	logic vld_s4;

	always_comb begin
		k = '0;
		for (int i = 31; i < V_W; i++) begin
			if (v[i]) begin
				k = 5'(i - 30);
			end
		end
		vs_c = 31'(v >> k);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		vs_s1 <= vs_c;
		a_s1 <= 19'(atm_pkg::CURVE_A40 >> (16 + k));
		b_s1 <= 35'(atm_pkg::CURVE_B48 >> (2 * k));
		d_s1 <= 23'(atm_pkg::CURVE_D40 >> (16 + k));
		e_s1 <= 46'(atm_pkg::CURVE_E48 >> (2 * k));

		sq_s2 <= 62'(vs_s1) * 62'(vs_s1);
		ta_s2 <= 50'(a_s1) * 50'(vs_s1);
		td_s2 <= 54'(d_s1) * 54'(vs_s1);
		b_s2 <= b_s1;
		e_s2 <= e_s1;

		ch_s3 <= 62'(sq_s2[61:24]) * 62'(atm_pkg::CURVE_C24);
		cl_s3 <= 24'((48'(sq_s2[23:0]) * 48'(atm_pkg::CURVE_C24)) >> 24);
		num_s3 <= 64'(sq_s2) + 64'(ta_s2) - 64'(b_s2);
		td_s3 <= td_s2;
		e_s3 <= e_s2;

		den_s4 <= atm_pkg::DEN_W'(ch_s3) + atm_pkg::DEN_W'(cl_s3)
			+ atm_pkg::DEN_W'(td_s3) + atm_pkg::DEN_W'(e_s3);
		neg_s4 <= num_s3[63];
		mag_s4 <= num_s3[63] ? atm_pkg::DEN_W'(-num_s3) : atm_pkg::DEN_W'(num_s3);
	end

	assign out_valid = vld_s4;
	assign mag = mag_s4;
	assign den = den_s4;
	assign neg = neg_s4;

endmodule

// ===== design/atm_div.sv =====
module atm_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [atm_pkg::DEN_W-1:0] mag,
	input  logic [atm_pkg::DEN_W-1:0] den,
	input  logic                      neg,
	output logic                      out_valid,
	output atm_pkg::curve_t           quo
);

	localparam int N = atm_pkg::DIV_STAGES;
	localparam int RW = atm_pkg::REM_W;
	localparam int DW = atm_pkg::DEN_W;
	localparam int QW = atm_pkg::QUO_W;

	logic [RW-1:0] rem_s [N];
	logic [DW-1:0] den_s [N];
	logic [QW-1:0] q_s [N];
	logic neg_s [N];
	logic vld_s [N];

	for (genvar st = 0; st < N; st++) begin : g_stage
		logic [RW-1:0] rem_i;
		logic [DW-1:0] den_i;
		logic [QW-1:0] q_i;
		logic neg_i;
		logic vld_i;
		logic [RW-1:0] rem_o;
		logic [QW-1:0] q_o;

		if (st == 0) begin : g_first
			assign rem_i = RW'(mag);
			assign den_i = den;
			assign q_i = '0;
			assign neg_i = neg;
			assign vld_i = in_valid;
		end else begin : g_next
			assign rem_i = rem_s[st-1];
			assign den_i = den_s[st-1];
			assign q_i = q_s[st-1];
			assign neg_i = neg_s[st-1];
			assign vld_i = vld_s[st-1];
		end

		always_comb begin
			logic [RW-1:0] dd;
			dd = {2'b00, den_i, 1'b0};
			rem_o = rem_i;
			q_o = q_i;
			for (int j = 0; j < atm_pkg::DIV_STEPS; j++) begin
				if (rem_o >= dd) begin
					rem_o = rem_o - dd;
					q_o = {q_o[QW-2:0], 1'b1};
				end else begin
					q_o = {q_o[QW-2:0], 1'b0};
				end
				rem_o = rem_o << 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[st] <= 1'b0;
			end else begin
				vld_s[st] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[st] <= rem_o;
			den_s[st] <= den_i;
			q_s[st] <= q_o;
			neg_s[st] <= neg_i;
		end
	end

	assign out_valid = vld_s[N-1];
	assign quo = neg_s[N-1] ? -atm_pkg::CURVE_W'(q_s[N-1]) : atm_pkg::CURVE_W'(q_s[N-1]);

endmodule

// ===== design/atm_out_mix.sv =====
module atm_out_mix (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  atm_pkg::curve_t r [3],
	output logic            out_valid,
	output logic [24:0]     c [3]
);

	logic signed [44:0] p_s1 [3][3];
	logic [24:0] c_comb [3];
	logic [24:0] c_s2 [3];
	logic vld_s1;
	logic vld_s2;

	always_comb begin
		logic signed [46:0] s;
		logic signed [46:0] t;
		s = '0;
		t = '0;
		for (int i = 0; i < 3; i++) begin
			s = 47'(p_s1[i][0]) + 47'(p_s1[i][1]) + 47'(p_s1[i][2]);
			t = s + 47'sd32768;
			if (s <= 0) begin
				c_comb[i] = '0;
			end else if (t[46:16] > 31'(atm_pkg::ONE_Q24)) begin
				c_comb[i] = atm_pkg::ONE_Q24;
			end else begin
				c_comb[i] = t[40:16];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				p_s1[i][j] <= 45'(atm_pkg::MAT_OUT[i*3+j]) * 45'(r[j]);
			end
		end
		c_s2 <= c_comb;
	end

	assign out_valid = vld_s2;
	assign c = c_s2;

endmodule

// ===== design/atm_srgb.sv =====
module atm_srgb (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [24:0] c,
	output logic        out_valid,
	output logic [7:0]  code
);

	localparam int N = atm_pkg::SRGB_SEARCH_STAGES;
	localparam int TW = atm_pkg::THR_W;
	localparam logic [256*TW-1:0] THR = atm_pkg::srgb_thresholds();

	logic [3:0] lc_comb;
	logic [24:0] c_s1;
	logic lin_s1;
	logic [3:0] lc_s1;
	logic vld_s1;
	logic [24:0] c_s [N];
	logic lin_s [N];
	logic [3:0] lc_s [N];
	logic [7:0] code_s [N];
	logic vld_s [N];

	always_comb begin
		logic [40:0] x;
		x = 41'(c) * atm_pkg::SRGB_LIN_MUL + atm_pkg::SRGB_LIN_BIAS;
		lc_comb = '0;
		for (int j = 1; j <= atm_pkg::SRGB_LIN_CODES; j++) begin
			if (x >= 41'(j) * atm_pkg::SRGB_LIN_STEP) begin
				lc_comb = lc_comb + 4'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		c_s1 <= c;
		lin_s1 <= (c <= atm_pkg::SRGB_LIN_LIMIT);
		lc_s1 <= lc_comb;
	end

	for (genvar st = 0; st < N; st++) begin : g_search
		logic [24:0] c_i;
		logic lin_i;
		logic [3:0] lc_i;
		logic [7:0] code_i;
		logic vld_i;
		logic [7:0] code_o;

		if (st == 0) begin : g_first
			assign c_i = c_s1;
			assign lin_i = lin_s1;
			assign lc_i = lc_s1;
			assign code_i = '0;
			assign vld_i = vld_s1;
		end else begin : g_next
			assign c_i = c_s[st-1];
			assign lin_i = lin_s[st-1];
			assign lc_i = lc_s[st-1];
			assign code_i = code_s[st-1];
			assign vld_i = vld_s[st-1];
		end

		always_comb begin
			logic [7:0] cand;
			cand = '0;
			code_o = code_i;
			for (int j = 0; j < 2; j++) begin
				cand = code_o | 8'(1 << (7 - 2 * st - j));
				if (c_i >= THR[cand*TW +: TW]) begin
					code_o = cand;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[st] <= 1'b0;
			end else begin
				vld_s[st] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			c_s[st] <= c_i;
			lin_s[st] <= lin_i;
			lc_s[st] <= lc_i;
			code_s[st] <= code_o;
		end
	end

	assign out_valid = vld_s[N-1];
	assign code = lin_s[N-1] ? 8'(lc_s[N-1]) : code_s[N-1];

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

	class tonemap_scoreboard;
		atm_pkg::pixel_out_t expected_display[$];
		int errors;

		function longint curve_q24(logic [63:0] v);
			int k;
			int f;
			logic [63:0] vs;
			logic [63:0] sq;
			logic [63:0] den;
			longint num;
			logic [127:0] mag;
			logic [127:0] q;
			k = 0;
			while (k < 20 && (v >> k) >= 64'h80000000) k++;
			vs = v >> k;
			f = 24 - k;
			sq = vs * vs;
			num = longint'(sq) + longint'((atm_pkg::CURVE_A40 >> (40 - f)) * vs)
				- longint'(atm_pkg::CURVE_B48 >> (48 - 2 * f));
			den = (sq >> 24) * atm_pkg::CURVE_C24
				+ (((sq & 64'hFFFFFF) * atm_pkg::CURVE_C24) >> 24)
				+ (atm_pkg::CURVE_D40 >> (40 - f)) * vs
				+ (atm_pkg::CURVE_E48 >> (48 - 2 * f));
			mag = (num < 0) ? 128'(-num) : 128'(num);
			q = (mag << 24) / 128'(den);
			return (num < 0) ? -longint'(q) : longint'(q);
		endfunction

		function bit code_reached(logic [63:0] c, int k);
			logic [319:0] lhs;
			logic [319:0] rhs;
			lhs = 320'd1;
			rhs = 320'd1;
			for (int i = 0; i < 5; i++) begin
				lhs = lhs * 320'(c);
				rhs = rhs * 320'(atm_pkg::ONE_Q24);
			end
			for (int i = 0; i < 12; i++) begin
				lhs = lhs * 320'd10761;
				rhs = rhs * 320'(40 * k + 541);
			end
			return lhs >= rhs;
		endfunction

		function logic [7:0] srgb_encode(logic [63:0] c);
			int code;
			if (c * 64'd10000000 <= 64'd31308 * 64'(atm_pkg::ONE_Q24))
				return 8'((64'd32946 * c + 64'd5 * 64'(atm_pkg::ONE_Q24))
					/ (64'd10 * 64'(atm_pkg::ONE_Q24)));
			code = 0;
			for (int b = 128; b != 0; b >>= 1) begin
				if (code + b <= 255 && code_reached(c, code + b)) code = code + b;
			end
			return 8'(code);
		endfunction

		function atm_pkg::pixel_out_t tonemap_pixel(atm_pkg::pixel_in_t p, logic [15:0] gain);
			logic [23:0] ch[3];
			logic [63:0] lin[3];
			logic [63:0] e;
			logic [63:0] acc;
			longint r[3];
			longint s;
			logic [63:0] c;
			logic [7:0] code[3];
			ch[0] = p.red_linear;
			ch[1] = p.green_linear;
			ch[2] = p.blue_linear;
			for (int i = 0; i < 3; i++) begin
				e = (64'(ch[i]) * 64'(gain) + 64'd2048) >> 12;
				if (e > 64'hFFFFFF) e = 64'hFFFFFF;
				lin[i] = e << (24 - atm_pkg::INPUT_FRAC_BITS_DEF);
			end
			for (int i = 0; i < 3; i++) begin
				acc = 0;
				for (int j = 0; j < 3; j++) acc += 64'(atm_pkg::MAT_IN[i*3+j]) * lin[j];
				r[i] = curve_q24((acc + 64'd32768) >> 16);
			end
			for (int i = 0; i < 3; i++) begin
				s = 0;
				for (int j = 0; j < 3; j++) s += longint'(atm_pkg::MAT_OUT[i*3+j]) * r[j];
				if (s <= 0) begin
					c = 0;
				end else begin
					c = (64'(s) + 64'd32768) >> 16;
					if (c > 64'(atm_pkg::ONE_Q24)) c = 64'(atm_pkg::ONE_Q24);
				end
				code[i] = srgb_encode(c);
			end
			return '{code[0], code[1], code[2]};
		endfunction

		function void note_pixel(atm_pkg::pixel_in_t p, logic [15:0] gain);
			expected_display.push_back(tonemap_pixel(p, gain));
		endfunction

		function void check_display(atm_pkg::pixel_out_t got);
			atm_pkg::pixel_out_t want;
			if (expected_display.size() == 0) begin
				$display("%0t: unexpected display beat %h", $time, got);
				errors++;
				return;
			end
			want = expected_display.pop_front();
			if (got.red_display !== want.red_display) begin
				$display("%0t: red expected %0d actual %0d", $time,
					want.red_display, got.red_display);
				errors++;
			end
			if (got.green_display !== want.green_display) begin
				$display("%0t: green expected %0d actual %0d", $time,
					want.green_display, got.green_display);
				errors++;
			end
			if (got.blue_display !== want.blue_display) begin
				$display("%0t: blue expected %0d actual %0d", $time,
					want.blue_display, got.blue_display);
				errors++;
			end
		endfunction
	endclass

	localparam int STALL_LIMIT = 5000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic cfg_wr_en;
	logic [15:0] cfg_wr_data;
	atm_pkg::pixel_in_t pixel;
	logic done;
	atm_pkg::pixel_out_t display;

	tonemap_scoreboard sb;
	logic [15:0] gain_now;
	int idle_pct;
	int stall_count;

	aces_tonemap_srgb_encode i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.pixel(pixel),
		.done(done),
		.display(display)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_now <= atm_pkg::EXPOSURE_RESET;
			stall_count <= 0;
		end else begin
			if (cfg_wr_en) gain_now <= cfg_wr_data;
			if (start && !busy) sb.note_pixel(pixel, gain_now);
			if (done) sb.check_display(display);
			if ((start && !busy) || done) begin
				stall_count <= 0;
			end else if (stall_count >= STALL_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end else begin
				stall_count <= stall_count + 1;
			end
		end
	end

	task send_pixel(atm_pkg::pixel_in_t p);
		start <= 1'b1;
		pixel <= p;
		@(posedge clk);
		while (busy) @(posedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			pixel <= atm_pkg::pixel_in_t'(72'({$urandom, $urandom, $urandom}));
			@(posedge clk);
		end
	endtask

	task send_rgb(logic [23:0] r, logic [23:0] g, logic [23:0] b);
		send_pixel('{r, g, b});
	endtask

	task drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.expected_display.size() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task write_gain(logic [15:0] g);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= g;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function logic [23:0] rand_level();
		case ($urandom_range(3))
			0: return 24'($urandom);
			1: return 24'($urandom_range(0, 24'h020000));
			2: return 24'($urandom_range(0, 24'h000400));
			default: return 24'($urandom_range(0, 24'h100000));
		endcase
	endfunction

	task random_pixels(int n);
		for (int i = 0; i < n; i++) begin
			idle_pct = (i < n / 3) ? 15 : (i < 2 * n / 3) ? 86 : 0;
			send_rgb(rand_level(), rand_level(), rand_level());
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		pixel = '0;
		idle_pct = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_rgb(24'h0, 24'h0, 24'h0);
		send_rgb(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		send_rgb(24'hFFFFFF, 24'h0, 24'h0);
		send_rgb(24'h0, 24'hFFFFFF, 24'h0);
		send_rgb(24'h0, 24'h0, 24'hFFFFFF);
		send_rgb(24'h010000, 24'h010000, 24'h010000);
		send_rgb(24'h000001, 24'h000010, 24'h0000C8);
		send_rgb(24'h000040, 24'h000080, 24'h000100);
		send_rgb(24'h008000, 24'h004000, 24'h002000);
		send_rgb(24'h100000, 24'h000000, 24'h000400);
		send_rgb(24'h000000, 24'h080000, 24'h000000);
		send_rgb(24'h555555, 24'hAAAAAA, 24'h123456);
		write_gain(16'hFFFF);
		send_rgb(24'h000000, 24'h000001, 24'h0FFFFF);
		send_rgb(24'h100000, 24'h200000, 24'hFFFFFF);
		send_rgb(24'h000800, 24'h000200, 24'h000080);
		write_gain(16'h0000);
		send_rgb(24'hFFFFFF, 24'h123456, 24'h000001);
		write_gain(16'h0001);
		send_rgb(24'hFFFFFF, 24'h800000, 24'h000800);
		drain();

		random_pixels(300);
		write_gain(16'h0800);
		random_pixels(250);
		write_gain(16'hFFFF);
		random_pixels(200);
		write_gain(16'(($urandom_range(1, 16)) * 1024 + $urandom_range(0, 1023)));
		random_pixels(250);
		write_gain(16'h1000);
		random_pixels(300);

		drain();
		if (sb.errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
design/atm_pkg.sv
design/atm_in_stage.sv
design/atm_curve.sv
design/atm_div.sv
design/atm_out_mix.sv
design/atm_srgb.sv
design/aces_tonemap_srgb_encode.sv
tb/tb.sv
